FILE: rtl/si_pkg.sv
// Shared constants, widths and beat types for the segment intersection pipeline.
`default_nettype none

package si_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_WIDTH   = 24;

  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = 2 * COORD_WIDTH + 1;
  localparam int QUO_W      = COORD_WIDTH + FRAC_BITS;
  localparam int SUM_W      = (QUO_W + 2 > OUT_WIDTH) ? QUO_W + 2 : OUT_WIDTH;
  localparam int DIV_STAGES = QUO_W;

  localparam logic signed [SUM_W-1:0] OUT_MAX =
    {{(SUM_W - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] OUT_MIN =
    {{(SUM_W - OUT_WIDTH + 1){1'b1}}, {(OUT_WIDTH - 1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } in_item_t;

  typedef struct packed {
    logic                        hit;
    logic signed [OUT_WIDTH-1:0] cross_x;
    logic signed [OUT_WIDTH-1:0] cross_y;
  } out_item_t;

  // one coordinate in the divider: partial remainder, dividend/quotient shifter
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] qd;
    logic             neg;
    coord_t           base;
  } div_lane_t;

  typedef struct packed {
    logic             hit;
    logic [DEN_W-1:0] den;
    div_lane_t        lane_x;
    div_lane_t        lane_y;
  } div_item_t;

endpackage

`default_nettype wire

FILE: rtl/si_front.sv
// Front pipeline: differences, cross products, hit test and numerator products.
`default_nettype none

module si_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire si_pkg::in_item_t   in_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output si_pkg::div_item_t       dn_item
);

  localparam int NX_W = si_pkg::DEN_W + si_pkg::COORD_WIDTH;

  typedef logic signed [si_pkg::DIFF_W-1:0] diff_t;
  typedef logic signed [si_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [si_pkg::NUM_W-1:0]  num_t;

  typedef struct packed {
    diff_t          s1x;
    diff_t          s1y;
    diff_t          s2x;
    diff_t          s2y;
    diff_t          dx;
    diff_t          dy;
    si_pkg::coord_t p0x;
    si_pkg::coord_t p0y;
  } st1_t;

  typedef struct packed {
    prod_t          m_d1;
    prod_t          m_d2;
    prod_t          m_s1;
    prod_t          m_s2;
    prod_t          m_t1;
    prod_t          m_t2;
    diff_t          s1x;
    diff_t          s1y;
    si_pkg::coord_t p0x;
    si_pkg::coord_t p0y;
  } st2_t;

  typedef struct packed {
    num_t           den;
    num_t           sn;
    num_t           tn;
    diff_t          s1x;
    diff_t          s1y;
    si_pkg::coord_t p0x;
    si_pkg::coord_t p0y;
  } st3_t;

  typedef struct packed {
    logic                           hit;
    logic [si_pkg::DEN_W-1:0]       den;
    logic [si_pkg::DEN_W-1:0]       tn;
    logic [si_pkg::COORD_WIDTH-1:0] ax;
    logic [si_pkg::COORD_WIDTH-1:0] ay;
    logic                           negx;
    logic                           negy;
    si_pkg::coord_t                 p0x;
    si_pkg::coord_t                 p0y;
  } st4_t;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  st1_t              st1_r, st1_nxt;
  st2_t              st2_r, st2_nxt;
  st3_t              st3_r, st3_nxt;
  st4_t              st4_r, st4_nxt;
  si_pkg::div_item_t st5_r, st5_nxt;

  diff_t s1x2, s1y2, s2x2, s2y2, dx2, dy2;
  num_t  den4, sn4, tn4, den_m4, tn_m4;
  diff_t s1x4, s1y4, ax_f4, ay_f4;
  logic  den_neg, den_pos, sn_ok_p, sn_ok_n, tn_ok_p, tn_ok_n;
  logic [NX_W-1:0] nx5, ny5;

  assign en5      = !v5_r || dn_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign dn_valid = v5_r;
  assign dn_item  = st5_r;

  // stage 1: direction vectors and start offset
  always_comb begin
    st1_nxt.s1x = diff_t'(in_data.first_end_x) - diff_t'(in_data.first_start_x);
    st1_nxt.s1y = diff_t'(in_data.first_end_y) - diff_t'(in_data.first_start_y);
    st1_nxt.s2x = diff_t'(in_data.second_end_x) - diff_t'(in_data.second_start_x);
    st1_nxt.s2y = diff_t'(in_data.second_end_y) - diff_t'(in_data.second_start_y);
    st1_nxt.dx  = diff_t'(in_data.first_start_x) - diff_t'(in_data.second_start_x);
    st1_nxt.dy  = diff_t'(in_data.first_start_y) - diff_t'(in_data.second_start_y);
    st1_nxt.p0x = in_data.first_start_x;
    st1_nxt.p0y = in_data.first_start_y;
  end

  // stage 2: six products
  assign s1x2 = st1_r.s1x;
  assign s1y2 = st1_r.s1y;
  assign s2x2 = st1_r.s2x;
  assign s2y2 = st1_r.s2y;
  assign dx2  = st1_r.dx;
  assign dy2  = st1_r.dy;

  always_comb begin
    st2_nxt.m_d1 = prod_t'(s1x2) * prod_t'(s2y2);
    st2_nxt.m_d2 = prod_t'(s2x2) * prod_t'(s1y2);
    st2_nxt.m_s1 = prod_t'(s1x2) * prod_t'(dy2);
    st2_nxt.m_s2 = prod_t'(s1y2) * prod_t'(dx2);
    st2_nxt.m_t1 = prod_t'(s2x2) * prod_t'(dy2);
    st2_nxt.m_t2 = prod_t'(s2y2) * prod_t'(dx2);
    st2_nxt.s1x  = st1_r.s1x;
    st2_nxt.s1y  = st1_r.s1y;
    st2_nxt.p0x  = st1_r.p0x;
    st2_nxt.p0y  = st1_r.p0y;
  end

  // stage 3: denominator and numerators
  always_comb begin
    st3_nxt.den = num_t'(prod_t'(st2_r.m_d1)) - num_t'(prod_t'(st2_r.m_d2));
    st3_nxt.sn  = num_t'(prod_t'(st2_r.m_s1)) - num_t'(prod_t'(st2_r.m_s2));
    st3_nxt.tn  = num_t'(prod_t'(st2_r.m_t1)) - num_t'(prod_t'(st2_r.m_t2));
    st3_nxt.s1x = st2_r.s1x;
    st3_nxt.s1y = st2_r.s1y;
    st3_nxt.p0x = st2_r.p0x;
    st3_nxt.p0y = st2_r.p0y;
  end

  // stage 4: range test against either sign of d, normalize to d > 0
  assign den4 = st3_r.den;
  assign sn4  = st3_r.sn;
  assign tn4  = st3_r.tn;
  assign s1x4 = st3_r.s1x;
  assign s1y4 = st3_r.s1y;

  assign den_neg = den4[si_pkg::NUM_W-1];
  assign den_pos = !den_neg && (den4 != '0);
  assign sn_ok_p = !sn4[si_pkg::NUM_W-1] && (sn4 <= den4);
  assign sn_ok_n = (sn4[si_pkg::NUM_W-1] || (sn4 == '0)) && (sn4 >= den4);
  assign tn_ok_p = !tn4[si_pkg::NUM_W-1] && (tn4 <= den4);
  assign tn_ok_n = (tn4[si_pkg::NUM_W-1] || (tn4 == '0)) && (tn4 >= den4);
  assign den_m4  = den_neg ? -den4 : den4;
  assign tn_m4   = den_neg ? -tn4 : tn4;
  assign ax_f4   = s1x4[si_pkg::DIFF_W-1] ? -s1x4 : s1x4;
  assign ay_f4   = s1y4[si_pkg::DIFF_W-1] ? -s1y4 : s1y4;

  always_comb begin
    st4_nxt.hit  = (den_pos && sn_ok_p && tn_ok_p) || (den_neg && sn_ok_n && tn_ok_n);
    st4_nxt.den  = den_m4[si_pkg::DEN_W-1:0];
    st4_nxt.tn   = tn_m4[si_pkg::DEN_W-1:0];
    st4_nxt.ax   = ax_f4[si_pkg::COORD_WIDTH-1:0];
    st4_nxt.ay   = ay_f4[si_pkg::COORD_WIDTH-1:0];
    st4_nxt.negx = s1x4[si_pkg::DIFF_W-1];
    st4_nxt.negy = s1y4[si_pkg::DIFF_W-1];
    st4_nxt.p0x  = st3_r.p0x;
    st4_nxt.p0y  = st3_r.p0y;
  end

  // stage 5: t numerator times |s1|, load divider
  assign nx5 = NX_W'(st4_r.tn) * NX_W'(st4_r.ax);
  assign ny5 = NX_W'(st4_r.tn) * NX_W'(st4_r.ay);

  always_comb begin
    st5_nxt.hit         = st4_r.hit;
    st5_nxt.den         = st4_r.den;
    st5_nxt.lane_x.rem  = nx5[NX_W-1:si_pkg::COORD_WIDTH];
    st5_nxt.lane_x.qd   = si_pkg::QUO_W'(nx5[si_pkg::COORD_WIDTH-1:0]) << si_pkg::FRAC_BITS;
    st5_nxt.lane_x.neg  = st4_r.negx;
    st5_nxt.lane_x.base = st4_r.p0x;
    st5_nxt.lane_y.rem  = ny5[NX_W-1:si_pkg::COORD_WIDTH];
    st5_nxt.lane_y.qd   = si_pkg::QUO_W'(ny5[si_pkg::COORD_WIDTH-1:0]) << si_pkg::FRAC_BITS;
    st5_nxt.lane_y.neg  = st4_r.negy;
    st5_nxt.lane_y.base = st4_r.p0y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) st1_r <= st1_nxt;
    if (en2) st2_r <= st2_nxt;
    if (en3) st3_r <= st3_nxt;
    if (en4) st4_r <= st4_nxt;
    if (en5) st5_r <= st5_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/si_div_step.sv
// One restoring division step for both coordinates, one quotient bit per stage.
`default_nettype none

module si_div_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire si_pkg::div_item_t  up_item,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output si_pkg::div_item_t       dn_item
);

  function automatic si_pkg::div_lane_t lane_step(input si_pkg::div_lane_t l,
                                                  input logic [si_pkg::DEN_W-1:0] den);
    logic [si_pkg::DEN_W:0] acc;
    logic [si_pkg::DEN_W:0] sub;
    logic                   take;
    si_pkg::div_lane_t      o;
    acc   = {l.rem, l.qd[si_pkg::QUO_W-1]};
    sub   = acc - {1'b0, den};
    take  = (acc >= {1'b0, den});
    o     = l;
    o.rem = take ? sub[si_pkg::DEN_W-1:0] : acc[si_pkg::DEN_W-1:0];
    o.qd  = {l.qd[si_pkg::QUO_W-2:0], take};
    return o;
  endfunction

  logic              v_r;
  logic              en;
  si_pkg::div_item_t item_r, item_nxt;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt        = up_item;
    item_nxt.lane_x = lane_step(up_item.lane_x, up_item.den);
    item_nxt.lane_y = lane_step(up_item.lane_y, up_item.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/si_back.sv
// Output stage: floor sign fix, add start point, saturate, result register.
`default_nettype none

module si_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire si_pkg::div_item_t  up_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output si_pkg::out_item_t       out_data
);

  localparam int QE_W = si_pkg::QUO_W + 1;

  function automatic logic signed [si_pkg::OUT_WIDTH-1:0] lane_point(
      input si_pkg::div_lane_t l);
    logic [QE_W-1:0]                q_ext;
    logic signed [si_pkg::SUM_W-1:0] off;
    logic signed [si_pkg::SUM_W-1:0] base_s;
    logic signed [si_pkg::SUM_W-1:0] sum;
    q_ext = {1'b0, l.qd};
    // negative product: -q, or -q-1 when a remainder is left (floor)
    if (l.neg) q_ext = ~q_ext + QE_W'(l.rem == '0);
    off    = si_pkg::SUM_W'($signed(q_ext));
    base_s = si_pkg::SUM_W'(l.base) <<< si_pkg::FRAC_BITS;
    sum    = base_s + off;
    if (sum > si_pkg::OUT_MAX) sum = si_pkg::OUT_MAX;
    if (sum < si_pkg::OUT_MIN) sum = si_pkg::OUT_MIN;
    return sum[si_pkg::OUT_WIDTH-1:0];
  endfunction

  logic              v_r;
  logic              en;
  si_pkg::out_item_t out_r, out_nxt;

  assign en        = !v_r || out_ready;
  assign up_ready  = en;
  assign out_valid = v_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt.hit     = up_item.hit;
    out_nxt.cross_x = up_item.hit ? lane_point(up_item.lane_x) : '0;
    out_nxt.cross_y = up_item.hit ? lane_point(up_item.lane_y) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_item.hit) |-> (up_item.lane_x.rem < up_item.den))
    else $error("x remainder not below denominator on a hit");
  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_item.hit) |-> (up_item.lane_y.rem < up_item.den))
    else $error("y remainder not below denominator on a hit");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_item.hit) |-> (up_item.den != '0))
    else $error("hit with zero denominator");
`endif

endmodule

`default_nettype wire

FILE: rtl/segment_intersection_top.sv
// Top level: parametric segment intersection pipeline, front, divider chain, output.
//
//   channel  ports                        beat
//   in       in_valid/in_ready/in_data     two segments, four endpoints (in_item_t)
//   out      out_valid/out_ready/out_data  hit flag, point x/y with FRAC_BITS (out_item_t)
//
// One segment pair per cycle while out_ready is high.
// The restoring divider takes one quotient bit per stage, x and y side by side.
// Synchronous active-low reset empties every stage; data registers are not cleared.
// Each stage holds while the next one is full and stalled, and takes a beat otherwise,
// so bubbles close up; in_ready drops only when all 30 stages are full and out_ready is low.
`default_nettype none

module segment_intersection_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire si_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output si_pkg::out_item_t      out_data
);

  logic              dv [si_pkg::DIV_STAGES+1];
  logic              dr [si_pkg::DIV_STAGES+1];
  si_pkg::div_item_t di [si_pkg::DIV_STAGES+1];

  si_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (dv[0]),
    .dn_ready (dr[0]),
    .dn_item  (di[0])
  );

  for (genvar g = 0; g < si_pkg::DIV_STAGES; g++) begin : g_div
    si_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[g]),
      .up_ready (dr[g]),
      .up_item  (di[g]),
      .dn_valid (dv[g+1]),
      .dn_ready (dr[g+1]),
      .dn_item  (di[g+1])
    );
  end

  si_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (dv[si_pkg::DIV_STAGES]),
    .up_ready  (dr[si_pkg::DIV_STAGES]),
    .up_item   (di[si_pkg::DIV_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.cross_x == '0 && out_data.cross_y == '0))
    else $error("nonzero point on a miss");
`endif

endmodule

`default_nettype wire
